FILE: hw/rtl/ngsf_pkg.sv
package ngsf_pkg;

   localparam int PATTERN_MAX_DEFAULT = 16;
   localparam int PATTERN_BYTES = 16;

   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   typedef enum logic [1:0] {
      REG_SHOW_HIDDEN    = 2'd0,
      REG_PATTERN_LENGTH = 2'd1,
      REG_PATTERN_LOW    = 2'd2,
      REG_PATTERN_HIGH   = 2'd3
   } reg_index_type;

   // control shared by every cell of the position chain
   typedef struct packed {
      logic glob;
      logic step;
      logic clear;
   } ngsf_ctrl_type;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/name_glob_substring_filter_unit.sv
// The result for the item that ends a name is registered onto rsp_passes the cycle after.
// Throughput: one name byte per cycle; the position chain advances every
// accepted byte and clears itself on the ending item.
// The ending item waits only while an earlier result is held by rsp_stall.
// Reset (synchronous, active high) clears the registers and restarts the match state.
module name_glob_substring_filter_unit #(
   parameter int PATTERN_MAX = ngsf_pkg::PATTERN_MAX_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_name_byte,
   input  logic        req_last_byte,
   input  logic        req_empty_name,
   input  logic        req_is_dir_like,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_passes,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);

   logic                  show_hidden_ff;
   logic [4:0]            pattern_length_ff;
   logic [63:0]           pattern_low_ff;
   logic [63:0]           pattern_high_ff;
   logic [127:0]          pattern_all;
   logic                  cfg_write;
   ngsf_pkg::reg_index_type cfg_index;

   logic [LEN_W-1:0]      used_len;
   logic                  len_zero;
   logic [PATTERN_MAX-1:0] wild_vec;
   logic                  glob;
   logic [7:0]            name_fold;

   logic [PATTERN_MAX:0]  close_chain;
   logic [PATTERN_MAX:0]  keep_chain;
   logic [PATTERN_MAX:0]  nclose_chain;

   logic                  state0_ff;
   logic                  state0_in;
   logic                  at_start_ff;
   logic                  at_start_in;
   logic                  dot_ff;
   logic                  dot_in;
   logic                  found_ff;
   logic                  found_in;

   logic                  fire;
   logic                  ending;
   logic                  step;
   logic                  dot_now;
   logic                  found_now;
   logic                  passes;
   ngsf_pkg::ngsf_ctrl_type ctrl;

   logic                  rsp_valid_ff;
   logic                  rsp_passes_ff;

   // configuration port
   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;
   assign cfg_index = ngsf_pkg::reg_index_type'(paddr[4:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         show_hidden_ff    <= 1'b0;
         pattern_length_ff <= 5'd0;
         pattern_low_ff    <= 64'd0;
         pattern_high_ff   <= 64'd0;
      end else if (cfg_write) begin
         case (cfg_index)
            ngsf_pkg::REG_SHOW_HIDDEN:    show_hidden_ff    <= pwdata[0];
            ngsf_pkg::REG_PATTERN_LENGTH: pattern_length_ff <= pwdata[4:0];
            ngsf_pkg::REG_PATTERN_LOW:    pattern_low_ff    <= pwdata;
            ngsf_pkg::REG_PATTERN_HIGH:   pattern_high_ff   <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (cfg_index)
         ngsf_pkg::REG_SHOW_HIDDEN:    prdata = {63'd0, show_hidden_ff};
         ngsf_pkg::REG_PATTERN_LENGTH: prdata = {59'd0, pattern_length_ff};
         ngsf_pkg::REG_PATTERN_LOW:    prdata = pattern_low_ff;
         ngsf_pkg::REG_PATTERN_HIGH:   prdata = pattern_high_ff;
         default:                      prdata = 64'd0;
      endcase
   end

   assign pattern_all = {pattern_high_ff, pattern_low_ff};

   // clamp the length to the cells that exist
   assign used_len = (pattern_length_ff > 5'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                           : pattern_length_ff[LEN_W-1:0];
   assign len_zero  = (used_len == '0);
   assign glob      = |wild_vec;
   assign name_fold = ngsf_pkg::fold_case(req_name_byte);

   // handshake: a non-ending item never waits on the output side
   assign ending    = req_empty_name | req_last_byte;
   assign req_stall = rsp_valid_ff & rsp_stall & ending;
   assign fire      = req_valid & ~req_stall;
   assign step      = fire & ~req_empty_name;

   assign ctrl.glob  = glob;
   assign ctrl.step  = step;
   assign ctrl.clear = fire & ending;

   assign close_chain[0]             = state0_ff;
   assign keep_chain[PATTERN_MAX]    = 1'b0;
   assign nclose_chain[0]            = keep_chain[0] | ~glob;

   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
      localparam logic [LEN_W-1:0] POS = LEN_W'(i);
      ngsf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .pat_byte   (pattern_all[8*i +: 8]),
         .name_fold  (name_fold),
         .en         (POS < used_len),
         .close_in   (close_chain[i]),
         .close_out  (close_chain[i+1]),
         .keep_in    (keep_chain[i+1]),
         .keep_out   (keep_chain[i]),
         .nclose_in  (nclose_chain[i]),
         .nclose_out (nclose_chain[i+1]),
         .wild       (wild_vec[i])
      );
   end

   // name-level state
   assign dot_now   = (step & at_start_ff) ? (req_name_byte == ngsf_pkg::CH_DOT) : dot_ff;
   assign found_now = found_ff | (step & ~glob & ~len_zero & nclose_chain[used_len]);

   always_comb begin
      if (~show_hidden_ff & dot_now) begin
         passes = 1'b0;
      end else if (len_zero | req_is_dir_like) begin
         passes = 1'b1;
      end else if (glob) begin
         passes = req_empty_name ? close_chain[used_len] : nclose_chain[used_len];
      end else begin
         passes = found_now;
      end
   end

   always_comb begin
      state0_in   = state0_ff;
      at_start_in = at_start_ff;
      dot_in      = dot_ff;
      found_in    = found_ff;
      if (ctrl.clear) begin
         state0_in   = 1'b1;
         at_start_in = 1'b1;
         dot_in      = 1'b0;
         found_in    = 1'b0;
      end else if (step) begin
         state0_in   = nclose_chain[0];
         at_start_in = 1'b0;
         dot_in      = dot_now;
         found_in    = found_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state0_ff   <= 1'b1;
         at_start_ff <= 1'b1;
         dot_ff      <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         state0_ff   <= state0_in;
         at_start_ff <= at_start_in;
         dot_ff      <= dot_in;
         found_ff    <= found_in;
      end
   end

   // output register: load on the ending item, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.clear) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_passes_ff <= 1'b0;
      end else if (ctrl.clear) begin
         rsp_passes_ff <= passes;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_passes = rsp_passes_ff;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      fire && ending |=> rsp_valid_ff)
      else $error("ending item produced no result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      fire && ending |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while held");

   a_name_cleared: assert property (@(posedge clock) disable iff (reset)
      fire && ending |=> state0_ff && at_start_ff && !dot_ff && !found_ff)
      else $error("name state not cleared after ending item");

   a_start_left: assert property (@(posedge clock) disable iff (reset)
      step && !ending |=> !at_start_ff)
      else $error("name start flag kept after a byte");

endmodule

FILE: hw/rtl/ngsf_cell.sv
module ngsf_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  ngsf_pkg::ngsf_ctrl_type ctrl,
   input  logic [7:0]            pat_byte,
   input  logic [7:0]            name_fold,
   input  logic                  en,
   input  logic                  close_in,
   output logic                  close_out,
   input  logic                  keep_in,
   output logic                  keep_out,
   input  logic                  nclose_in,
   output logic                  nclose_out,
   output logic                  wild
);

   logic is_star;
   logic is_quest;
   logic star_live;
   logic match;
   logic move;
   logic next_pre;
   logic state_ff;
   logic state_in;

   assign is_star   = (pat_byte == ngsf_pkg::CH_STAR);
   assign is_quest  = (pat_byte == ngsf_pkg::CH_QUEST);
   assign star_live = ctrl.glob & is_star & en;
   assign wild      = en & (is_star | is_quest);

   // star closure over the held position, then over the advanced one
   assign close_out = (state_ff & en) | (close_in & star_live);

   assign match     = (ctrl.glob & is_quest) |
                      (ngsf_pkg::fold_case(pat_byte) == name_fold);
   assign keep_out  = close_in & star_live;
   assign move      = close_in & en & ~(ctrl.glob & is_star) & match;
   assign next_pre  = (move | keep_in) & en;
   assign nclose_out = next_pre | (nclose_in & star_live);

   always_comb begin
      state_in = state_ff;
      if (ctrl.clear) begin
         state_in = 1'b0;
      end else if (ctrl.step) begin
         state_in = nclose_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
